[rtl/sdtq_pkg.sv]
// Shared types and constants of the sorted deadline timer queue.
`default_nettype none

package sdtq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_BITS    = 8;

    localparam int DEADLINE_W  = 64;
    localparam int RATE_W      = 32;
    localparam int DELAY_W     = 16;
    localparam int TAG_W       = 8;
    localparam int PENDING_W   = 5;
    localparam int PRODUCT_W   = RATE_W + DELAY_W;

    localparam logic [RATE_W-1:0] TICK_RATE_RESET = 32'd62500000;

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [DELAY_W-1:0] delay_seconds;
        logic [TAG_W-1:0]   event_tag;
    } in_item_t;

    typedef struct packed {
        logic                  add_accepted;
        logic                  queue_full_error;
        logic                  fired;
        logic [TAG_W-1:0]      fired_tag;
        logic [PENDING_W-1:0]  pending_count;
        logic                  timer_armed;
        logic [DEADLINE_W-1:0] head_deadline;
    } out_item_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic pop;
    } chain_ctrl_t;

endpackage

`default_nettype wire

[rtl/sdtq_cell.sv]
// One slot of the sorted chain: holds an entry, shifts right on insert, left on pop.
`default_nettype none

module sdtq_cell
    import sdtq_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  chain_ctrl_t           ctrl,
    input  wire  [DEADLINE_W-1:0] new_deadline,
    input  wire  [TAG_BITS-1:0]   new_tag,
    input  wire  [DEADLINE_W-1:0] prev_deadline,
    input  wire  [TAG_BITS-1:0]   prev_tag,
    input  wire                   prev_valid,
    input  wire                   prev_after,
    input  wire  [DEADLINE_W-1:0] next_deadline,
    input  wire  [TAG_BITS-1:0]   next_tag,
    input  wire                   next_valid,
    output logic [DEADLINE_W-1:0] deadline,
    output logic [TAG_BITS-1:0]   tag,
    output logic                  valid,
    output logic                  after
);

    logic [DEADLINE_W-1:0] deadline_reg, deadline_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic                  valid_reg, valid_next;

    // insert point is at or before this slot: empty, or strictly later deadline
    assign after = !valid_reg || (deadline_reg > new_deadline);

    always_comb begin
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        valid_next    = valid_reg;
        if (ctrl.ins) begin
            valid_next = valid_reg | prev_valid;
            if (after) begin
                if (prev_after) begin
                    deadline_next = prev_deadline;
                    tag_next      = prev_tag;
                end else begin
                    deadline_next = new_deadline;
                    tag_next      = new_tag;
                end
            end
        end else if (ctrl.pop) begin
            deadline_next = next_deadline;
            tag_next      = next_tag;
            valid_next    = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
    end

    assign deadline = deadline_reg;
    assign tag      = tag_reg;
    assign valid    = valid_reg;

endmodule

`default_nettype wire

[rtl/sdtq_chain.sv]
// Row of queue cells kept sorted by deadline; slot 0 is the head.
`default_nettype none

module sdtq_chain
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  chain_ctrl_t           ctrl,
    input  wire  [DEADLINE_W-1:0] new_deadline,
    input  wire  [TAG_BITS-1:0]   new_tag,
    output logic [DEADLINE_W-1:0] head_deadline,
    output logic [TAG_BITS-1:0]   head_tag,
    output logic                  head_valid
);

    logic [DEADLINE_W-1:0] dl     [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   tg     [QUEUE_DEPTH];
    logic                  vl     [QUEUE_DEPTH];
    logic                  af     [QUEUE_DEPTH];
    logic [DEADLINE_W-1:0] prv_dl [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   prv_tg [QUEUE_DEPTH];
    logic                  prv_vl [QUEUE_DEPTH];
    logic                  prv_af [QUEUE_DEPTH];
    logic [DEADLINE_W-1:0] nxt_dl [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   nxt_tg [QUEUE_DEPTH];
    logic                  nxt_vl [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            // head always becomes valid on insert and takes the new entry if it moves
            assign prv_dl[i] = new_deadline;
            assign prv_tg[i] = new_tag;
            assign prv_vl[i] = 1'b1;
            assign prv_af[i] = 1'b0;
        end else begin : g_mid
            assign prv_dl[i] = dl[i-1];
            assign prv_tg[i] = tg[i-1];
            assign prv_vl[i] = vl[i-1];
            assign prv_af[i] = af[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nxt_dl[i] = '0;
            assign nxt_tg[i] = '0;
            assign nxt_vl[i] = 1'b0;
        end else begin : g_body
            assign nxt_dl[i] = dl[i+1];
            assign nxt_tg[i] = tg[i+1];
            assign nxt_vl[i] = vl[i+1];
        end

        sdtq_cell #(
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .new_deadline (new_deadline),
            .new_tag      (new_tag),
            .prev_deadline(prv_dl[i]),
            .prev_tag     (prv_tg[i]),
            .prev_valid   (prv_vl[i]),
            .prev_after   (prv_af[i]),
            .next_deadline(nxt_dl[i]),
            .next_tag     (nxt_tg[i]),
            .next_valid   (nxt_vl[i]),
            .deadline     (dl[i]),
            .tag          (tg[i]),
            .valid        (vl[i]),
            .after        (af[i])
        );
    end

    assign head_deadline = dl[0];
    assign head_tag      = tg[0];
    assign head_valid    = vl[0];

endmodule

`default_nettype wire

[rtl/sorted_deadline_timer_queue_core.sv]
// Top level of the sorted deadline timer queue: sequencer, tick counter, output register.
// Usage:
//   s_ channel (valid/ready) carries one in_item_t beat: an add (delay in
//   seconds plus tag) or a tick that advances the 64-bit tick count by one.
//   m_ channel (valid/ready) returns exactly one out_item_t beat per input
//   beat: add status, fired tag, pending count, armed flag and the head
//   deadline, which is the compare value for the shared hardware timer.
//   cfg_ channel writes tick_rate (ticks per second); write it only while
//   the block is idle. cfg_ready is always high.
// Timing:
//   Each beat walks four phases: accept (delay times tick_rate into a
//   register), calc (64-bit deadline add or count increment), apply (one
//   broadcast compare and shift of the cell chain), report (output register
//   load). m_valid rises at the report load, which waits on m_ready; a new
//   beat is accepted only once the last is reported. The chain updates all
//   slots together, so queue depth does not lengthen a beat.
// Reset (aresetn low, synchronous): count, queue and output valid clear,
//   tick_rate returns to 62500000.
// Stall: a result waiting on m_ready holds the report phase; a new s_ beat
//   can still be taken and worked on up to that point.
`default_nettype none

module sorted_deadline_timer_queue_core
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  wire               aclk,
    input  wire               aresetn,
    // input beats
    input  wire               s_valid,
    output logic              s_ready,
    input  in_item_t          s_item,
    // result beats
    output logic              m_valid,
    input  wire               m_ready,
    output out_item_t         m_item,
    // tick_rate write
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire  [RATE_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // sequencer phases
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [RATE_W-1:0]     tick_rate_reg, tick_rate_next;
    logic [DEADLINE_W-1:0] now_reg, now_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             out_reg, out_next;

    // per-beat working registers (no reset needed)
    logic                  op_reg, op_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic [PRODUCT_W-1:0]  prod_reg, prod_next;
    logic [DEADLINE_W-1:0] deadline_reg, deadline_next;
    logic                  accepted_reg, accepted_next;
    logic                  full_reg, full_next;
    logic                  fired_reg, fired_next;
    logic [TAG_W-1:0]      fired_tag_reg, fired_tag_next;

    chain_ctrl_t           ctrl;
    logic [DEADLINE_W-1:0] head_deadline;
    logic [TAG_BITS-1:0]   head_tag;
    logic                  head_valid;
    logic                  out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        tick_rate_next = tick_rate_reg;
        now_next       = now_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        op_next        = op_reg;
        tag_next       = tag_reg;
        prod_next      = prod_reg;
        deadline_next  = deadline_reg;
        accepted_next  = accepted_reg;
        full_next      = full_reg;
        fired_next     = fired_reg;
        fired_tag_next = fired_tag_reg;
        ctrl           = '0;

        if (cfg_valid) begin
            tick_rate_next = cfg_wdata;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_item.operation;
                    tag_next   = TAG_BITS'(s_item.event_tag);
                    prod_next  = PRODUCT_W'(tick_rate_reg) * PRODUCT_W'(s_item.delay_seconds);
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (op_reg == OP_ADD) begin
                    deadline_next = now_reg + DEADLINE_W'(prod_reg);
                end else begin
                    now_next = now_reg + DEADLINE_W'(1);
                end
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                accepted_next  = 1'b0;
                full_next      = 1'b0;
                fired_next     = 1'b0;
                fired_tag_next = '0;
                if (op_reg == OP_ADD) begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        full_next = 1'b1;
                    end else begin
                        ctrl.ins      = 1'b1;
                        accepted_next = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end else if (head_valid && (head_deadline <= now_reg)) begin
                    ctrl.pop       = 1'b1;
                    fired_next     = 1'b1;
                    fired_tag_next = TAG_W'(head_tag);
                    count_next     = count_reg - CNT_W'(1);
                end
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (out_free) begin
                    out_next.add_accepted     = accepted_reg;
                    out_next.queue_full_error = full_reg;
                    out_next.fired            = fired_reg;
                    out_next.fired_tag        = fired_tag_reg;
                    out_next.pending_count    = PENDING_W'(count_reg);
                    out_next.timer_armed      = head_valid;
                    out_next.head_deadline    = head_valid ? head_deadline : '0;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_rate_reg <= TICK_RATE_RESET;
            now_reg       <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tick_rate_reg <= tick_rate_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg       <= out_next;
        op_reg        <= op_next;
        tag_reg       <= tag_next;
        prod_reg      <= prod_next;
        deadline_reg  <= deadline_next;
        accepted_reg  <= accepted_next;
        full_reg      <= full_next;
        fired_reg     <= fired_next;
        fired_tag_reg <= fired_tag_next;
    end

    sdtq_chain #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS   (TAG_BITS)
    ) u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .new_deadline (deadline_reg),
        .new_tag      (tag_reg),
        .head_deadline(head_deadline),
        .head_tag     (head_tag),
        .head_valid   (head_valid)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

[rtl/sdtq_checker.sv]
// Port-level checks of the timer queue core, bound to the top level.
`default_nettype none

module sdtq_checker
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input out_item_t m_item
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result beat changed while stalled");

    // one beat in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in flight");

    // disarmed timer shows an empty queue and a zero compare value
    a_disarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.timer_armed |->
            m_item.pending_count == '0 && m_item.head_deadline == '0)
        else $error("disarmed result with pending state");

    // rejected add only when the queue is full, and never with a fire
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.queue_full_error |->
            m_item.pending_count == PENDING_W'(QUEUE_DEPTH) &&
            !m_item.add_accepted && !m_item.fired)
        else $error("full flag with inconsistent result");

endmodule

bind sorted_deadline_timer_queue_core sdtq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_sdtq_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item (m_item)
);

`default_nettype wire
